// ===== rtl/ubfc_pkg.sv =====
// ubfc_pkg: shared constants, fixed-point coefficients and types for the
// uyvy to bgr converter with vertical flip. No dependencies.
package ubfc_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_HEIGHT     = 4096;
	localparam int COEF_FRAC_BITS = 14;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 13;
	localparam int ROW_W     = 12;
	localparam int PAIR_W    = 11;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

	// coefficients rounded half up from thousandths
	localparam longint K_BU_L = ((longint'(1770) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GU_L = ((longint'(344) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GV_L = ((longint'(714) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_RV_L = ((longint'(1403) << COEF_FRAC_BITS) + 500) / 1000;

	// largest coefficient is below 2.0, so F+1 magnitude bits plus a sign bit
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int PROD_W = COEF_W + PIX_W;
	localparam int ACC_W  = PROD_W + 2;

	localparam logic signed [COEF_W-1:0] K_BU = COEF_W'(K_BU_L);
	localparam logic signed [COEF_W-1:0] K_GU = COEF_W'(K_GU_L);
	localparam logic signed [COEF_W-1:0] K_GV = COEF_W'(K_GV_L);
	localparam logic signed [COEF_W-1:0] K_RV = COEF_W'(K_RV_L);

	localparam logic [PIX_W-1:0] CHROMA_ZERO = PIX_W'(128);
	localparam logic [PIX_W-1:0] PIX_MAX     = PIX_W'(255);

	typedef struct packed {
		logic signed [PROD_W-1:0] bu;
		logic signed [PROD_W-1:0] gu;
		logic signed [PROD_W-1:0] gv;
		logic signed [PROD_W-1:0] rv;
	} chroma_prod_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} bgr_t;

	typedef struct packed {
		logic [ROW_W-1:0]  dest_row;
		logic [PAIR_W-1:0] dest_pair;
		logic              frame_end;
	} pos_t;

endpackage

// ===== rtl/ubfc_if.sv =====
// ubfc_if: valid/ready channel interfaces for macropixel input, bgr pair
// output and register writes. Depends on ubfc_pkg.
interface ubfc_in_if import ubfc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_red;
	logic [PIX_W-1:0] luma_second;

	modport source (output valid, chroma_blue, luma_first, chroma_red, luma_second,
		input ready);
	modport sink (input valid, chroma_blue, luma_first, chroma_red, luma_second,
		output ready);
endinterface

interface ubfc_out_if import ubfc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  blue_first;
	logic [PIX_W-1:0]  green_first;
	logic [PIX_W-1:0]  red_first;
	logic [PIX_W-1:0]  blue_second;
	logic [PIX_W-1:0]  green_second;
	logic [PIX_W-1:0]  red_second;
	logic [ROW_W-1:0]  dest_row;
	logic [PAIR_W-1:0] dest_pair;
	logic              frame_end;

	modport source (output valid, blue_first, green_first, red_first, blue_second,
		green_second, red_second, dest_row, dest_pair, frame_end, input ready);
	modport sink (input valid, blue_first, green_first, red_first, blue_second,
		green_second, red_second, dest_row, dest_pair, frame_end, output ready);
endinterface

interface ubfc_cfg_if import ubfc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ubfc_chroma.sv =====
// ubfc_chroma: chroma products shared by both pixel lanes, one register stage.
// Depends on ubfc_pkg.
module ubfc_chroma import ubfc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [PIX_W-1:0] chroma_blue,
	input  logic [PIX_W-1:0] chroma_red,
	output chroma_prod_t     prod_s1
);

	logic signed [PIX_W-1:0] u_c;
	logic signed [PIX_W-1:0] v_c;

	// offset binary to two's complement
	assign u_c = signed'(chroma_blue ^ CHROMA_ZERO);
	assign v_c = signed'(chroma_red ^ CHROMA_ZERO);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.bu <= PROD_W'(K_BU * u_c);
			prod_s1.gu <= PROD_W'(K_GU * u_c);
			prod_s1.gv <= PROD_W'(K_GV * v_c);
			prod_s1.rv <= PROD_W'(K_RV * v_c);
		end
	end

endmodule

// ===== rtl/ubfc_lane.sv =====
// ubfc_lane: one pixel lane, adds luma to the chroma products and clamps to
// a byte per color. Depends on ubfc_pkg.
module ubfc_lane import ubfc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [PIX_W-1:0] luma_s1,
	input  chroma_prod_t     prod_s1,
	output bgr_t             pix_s2
);

	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_b;
	logic signed [ACC_W-1:0] acc_g;
	logic signed [ACC_W-1:0] acc_r;

	function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [ACC_W-1:0] a);
		logic [PIX_W-1:0] r;
		if (a[ACC_W-1]) begin
			r = '0;
		end else if (|a[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
			r = PIX_MAX;
		end else begin
			r = a[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
		end
		return r;
	endfunction

	assign base  = signed'(ACC_W'(luma_s1) << COEF_FRAC_BITS);
	assign acc_b = base + ACC_W'(prod_s1.bu);
	assign acc_g = base - ACC_W'(prod_s1.gu) - ACC_W'(prod_s1.gv);
	assign acc_r = base + ACC_W'(prod_s1.rv);

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2.blue  <= clamp_pix(acc_b);
			pix_s2.green <= clamp_pix(acc_g);
			pix_s2.red   <= clamp_pix(acc_r);
		end
	end

endmodule

// ===== rtl/ubfc_pos.sv =====
// ubfc_pos: pair and row counters, flipped destination row and frame end for
// the beat being accepted. Depends on ubfc_pkg.
module ubfc_pos import ubfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [CFG_W-1:0] frame_width,
	input  logic [CFG_W-1:0] frame_height,
	output pos_t             pos,
	output logic             last_pair
);

	logic [PAIR_W-1:0] pair_q;
	logic [ROW_W-1:0]  row_q;
	logic [CFG_W-1:0]  w_eff;
	logic [CFG_W-1:0]  h_eff;
	logic [ROW_W-1:0]  pairs;
	logic [ROW_W-1:0]  pairs_m1;
	logic [ROW_W-1:0]  h_m1;
	logic              last_row;

	assign w_eff    = (frame_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : frame_width;
	assign h_eff    = (frame_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : frame_height;
	assign pairs    = w_eff[CFG_W-1:1];
	assign pairs_m1 = (pairs == '0) ? '0 : pairs - ROW_W'(1);
	assign h_m1     = (h_eff == '0) ? '0 : ROW_W'(h_eff - CFG_W'(1));

	// counters past a shrunk size still end the row or frame
	assign last_pair = {1'b0, pair_q} >= pairs_m1;
	assign last_row  = row_q >= h_m1;

	assign pos.dest_row  = last_row ? '0 : h_m1 - row_q;
	assign pos.dest_pair = pair_q;
	assign pos.frame_end = last_pair && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (last_pair) begin
				pair_q <= '0;
				row_q  <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				pair_q <= pair_q + PAIR_W'(1);
			end
		end
	end

endmodule

// ===== rtl/uyvy_to_bgr_flip_converter.sv =====
// uyvy_to_bgr_flip_converter: top level, register file, two pixel lanes and
// the output stage. Depends on ubfc_pkg, ubfc_if, ubfc_chroma, ubfc_lane, ubfc_pos.
//
// pix_in takes one uyvy macropixel per beat (u, y0, v, y1) in raster order.
// pix_out gives the two pixels as blue, green, red bytes together with the
// destination row of the vertically flipped frame, the pair column and a
// frame end flag on the last pair of the frame.
// cfg writes frame_width (index 0) and frame_height (index 1); it is always
// ready and is meant to be used while no beats are in flight.
// An input beat passes the chroma multiply stage and then the per-lane add
// and clamp stage, which is also the output register. Throughput is one
// macropixel per cycle while the receiver does not stall, both pixels
// handled by two lanes side by side.
// When the receiver stalls the output register holds, the first stage takes
// one more beat if empty, and then pix_in.ready drops until the output moves.
// Reset clears the pipeline valids and the pair and row counters and loads
// the registers with 640 by 480.
module uyvy_to_bgr_flip_converter import ubfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ubfc_cfg_if.sink   cfg,
	ubfc_in_if.sink    pix_in,
	ubfc_out_if.source pix_out
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             v_s1;
	logic             v_s2;
	logic             ready_s1;
	logic             ready_s2;
	logic             in_acc;
	logic             last_pair;
	logic [PIX_W-1:0] y0_s1;
	logic [PIX_W-1:0] y1_s1;
	pos_t             pos;
	pos_t             pos_s1;
	pos_t             pos_s2;
	chroma_prod_t     prod_s1;
	bgr_t             pix0_s2;
	bgr_t             pix1_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ready_s2     = !v_s2 || pix_out.ready;
	assign ready_s1     = !v_s1 || ready_s2;
	assign pix_in.ready = ready_s1;
	assign in_acc       = pix_in.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= pix_in.valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	ubfc_pos u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.frame_width  (width_q),
		.frame_height (height_q),
		.pos          (pos),
		.last_pair    (last_pair)
	);

	ubfc_chroma u_chroma (
		.clk         (clk),
		.en          (ready_s1),
		.chroma_blue (pix_in.chroma_blue),
		.chroma_red  (pix_in.chroma_red),
		.prod_s1     (prod_s1)
	);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			y0_s1  <= pix_in.luma_first;
			y1_s1  <= pix_in.luma_second;
			pos_s1 <= pos;
		end
		if (ready_s2) begin
			pos_s2 <= pos_s1;
		end
	end

	ubfc_lane u_lane0 (
		.clk     (clk),
		.en      (ready_s2),
		.luma_s1 (y0_s1),
		.prod_s1 (prod_s1),
		.pix_s2  (pix0_s2)
	);

	ubfc_lane u_lane1 (
		.clk     (clk),
		.en      (ready_s2),
		.luma_s1 (y1_s1),
		.prod_s1 (prod_s1),
		.pix_s2  (pix1_s2)
	);

	// merge both lanes and the position into one beat
	assign pix_out.valid        = v_s2;
	assign pix_out.blue_first   = pix0_s2.blue;
	assign pix_out.green_first  = pix0_s2.green;
	assign pix_out.red_first    = pix0_s2.red;
	assign pix_out.blue_second  = pix1_s2.blue;
	assign pix_out.green_second = pix1_s2.green;
	assign pix_out.red_second   = pix1_s2.red;
	assign pix_out.dest_row     = pos_s2.dest_row;
	assign pix_out.dest_pair    = pos_s2.dest_pair;
	assign pix_out.frame_end    = pos_s2.frame_end;

	a_frame_end_row0: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.frame_end |-> pix_out.dest_row == '0)
		else $error("frame end beat with nonzero destination row");

	a_full_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !pix_out.ready |-> !pix_in.ready)
		else $error("input accepted while both stages are full and stalled");

	a_row_wraps_pair: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_pair |=> pos.dest_pair == '0)
		else $error("pair counter did not wrap after the last pair");

	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("output valid without a beat in the first stage");

endmodule
